// File: rtl/core/assert_macros.svh
// Assertion macros shared by the tokenizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an antecedent is followed in the next cycle by a consequent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/glt_pkg.sv
// Types, codes and character classes of the G-code line tokenizer.
`default_nettype none

package glt_pkg;

  typedef enum logic [2:0] {
    TK_WORD       = 3'd0,
    TK_LINENO     = 3'd1,
    TK_CMT_START  = 3'd2,
    TK_CMT_CHAR   = 3'd3,
    TK_ERROR      = 3'd4,
    TK_EOL        = 3'd5
  } tok_kind_t;

  typedef enum logic [2:0] {
    ERR_MULTI_POINT  = 3'd0,
    ERR_EMPTY_LINENO = 3'd1,
    ERR_BAD_START    = 3'd2,
    ERR_UNK_WORD     = 3'd3,
    ERR_UNK_NUM      = 3'd4,
    ERR_DIGITS       = 3'd5
  } err_code_t;

  typedef enum logic [1:0] {
    LX_START  = 2'd0,
    LX_LINENO = 2'd1,
    LX_WSTART = 2'd2,
    LX_WNUM   = 2'd3
  } lx_mode_t;

  typedef enum logic [2:0] {
    CM_NONE   = 3'd0,
    CM_INLINE = 3'd1,
    CM_EOL    = 3'd2,
    CM_UNK    = 3'd3,
    CM_UNKNUM = 3'd4
  } cm_mode_t;

  localparam int MANT_W   = 30;
  localparam int FRAC_W   = 4;
  localparam int DIV_W    = 5;
  localparam int MAX_RES  = 2;

  localparam logic [DIV_W-1:0] DIV_CAP = 5'd16;
  localparam logic [31:0] RECIP_10 = 32'hCCCCCCCD;

  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_N_UP    = 8'h4E;
  localparam logic [7:0] CH_N_LOW   = 8'h6E;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_POINT   = 8'h2E;

  typedef struct packed {
    tok_kind_t         kind;
    logic [7:0]        letter;
    logic              neg;
    logic [MANT_W-1:0] mant;
    logic [FRAC_W-1:0] frac;
    err_code_t         err;
    logic              bd;
    logic              pct;
    logic              last;
  } tok_t;

  function automatic tok_t mk_tok(tok_kind_t kind, logic [7:0] letter, logic neg,
                                  logic [MANT_W-1:0] mant, logic [FRAC_W-1:0] frac,
                                  err_code_t err, logic bd, logic pct);
    tok_t t;
    t.kind   = kind;
    t.letter = letter;
    t.neg    = neg;
    t.mant   = mant;
    t.frac   = frac;
    t.err    = err;
    t.bd     = bd;
    t.pct    = pct;
    t.last   = 1'b0;
    return t;
  endfunction

  function automatic tok_t mk_err(err_code_t err);
    return mk_tok(TK_ERROR, 8'h00, 1'b0, '0, '0, err, 1'b0, 1'b0);
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c >= 8'h09 && c <= 8'h0D) || c == 8'h20 || c == 8'h85 || c == 8'hA0;
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
           c == 8'hAA || c == 8'hB5 || c == 8'hBA ||
           (c >= 8'hC0 && c != 8'hD7 && c != 8'hF7);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_numish(logic [7:0] c);
    return is_digit(c) || c == CH_PLUS || c == CH_MINUS || c == CH_POINT;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/glt_in_if.sv
// Input channel of the tokenizer: one character or an end of line per item.
`default_nettype none

interface glt_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] char_code;

  modport source (output valid, output req_type, output char_code, input ready);
  modport sink   (input valid, input req_type, input char_code, output ready);
endinterface

`default_nettype wire

// File: rtl/core/glt_out_if.sv
// Result channel of the tokenizer: one token per item.
`default_nettype none

interface glt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  token_kind;
  logic [7:0]  letter_or_char;
  logic        value_negative;
  logic [29:0] mantissa;
  logic [3:0]  fraction_digits;
  logic [2:0]  error_code;
  logic        block_delete;
  logic        percent_line;
  logic        last_of_run;

  modport source (output valid, output token_kind, output letter_or_char,
                  output value_negative, output mantissa, output fraction_digits,
                  output error_code, output block_delete, output percent_line,
                  output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input letter_or_char,
                  input value_negative, input mantissa, input fraction_digits,
                  input error_code, input block_delete, input percent_line,
                  input last_of_run, output ready);
endinterface

`default_nettype wire

// File: rtl/core/gcode_line_tokenizer.sv
// G-code line tokenizer: lexer state, token buffer and output channel.
//
// in_item carries one character (req_type 0) or an end of line (req_type 1)
// per item; out_tok delivers tokens, last_of_run marking the final token
// caused by an input item. An item may cause zero, one or two tokens.
// Each accepted item is lexed in the cycle it arrives and its tokens are
// written into a two-entry token buffer; the first token is valid on
// out_tok the next cycle. One item is taken per cycle as long as each
// item makes at most one token and the sink keeps up; an item that makes
// two tokens holds off the next item until its second token is taken.
// A line number with fraction digits is scaled down by one decimal digit
// per cycle by a reciprocal multiplier on the head buffer entry, and is
// held back from out_tok until its fraction digits (at most 16) are gone.
// While the sink stalls, the head token holds and in_item.ready stays low
// once the buffer holds anything but a last token that is being taken.
// Synchronous reset empties the buffer and returns the lexer to line start;
// an end-of-line item does the same to the lexer after its tokens.
`default_nettype none
`include "assert_macros.svh"

module gcode_line_tokenizer #(
  parameter int MAX_DIGITS = 9
) (
  input  logic      clk,
  input  logic      rst_n,
  glt_in_if.sink    in_item,
  glt_out_if.source out_tok
);

  localparam int DW = $clog2(MAX_DIGITS + 1);

  // lexer state
  glt_pkg::lx_mode_t          lx_r, lx_nxt;
  glt_pkg::cm_mode_t          cm_r, cm_nxt;
  logic [7:0]                 letter_r, letter_nxt;
  logic                       sign_r, sign_nxt;
  logic [glt_pkg::MANT_W-1:0] acc_r, acc_nxt;
  logic [DW-1:0]              dcnt_r, dcnt_nxt;
  logic [DW-1:0]              fcnt_r, fcnt_nxt;
  logic                       point_r, point_nxt;
  logic                       ignore_r, ignore_nxt;
  logic                       nonempty_r, nonempty_nxt;
  logic                       del_r, del_nxt;
  logic                       pct_r, pct_nxt;

  // token buffer
  glt_pkg::tok_t              slot_r [glt_pkg::MAX_RES];
  glt_pkg::tok_t              res_nxt [glt_pkg::MAX_RES];
  logic [1:0]                 cnt_r;
  logic [1:0]                 n_res;
  logic [glt_pkg::DIV_W-1:0]  div_r, div0_nxt;

  logic [7:0]                 c;
  logic                       accept;
  logic                       pop;
  logic                       ws;
  logic                       uk;
  glt_pkg::cm_mode_t          ucm;
  logic                       tv_take;
  logic [glt_pkg::DIV_W-1:0]  ln_div;
  logic [61:0]                prod;
  logic [glt_pkg::MANT_W-1:0] mant_q;

  assign c      = in_item.char_code;
  assign accept = in_item.valid && in_item.ready;
  assign pop    = out_tok.valid && out_tok.ready;

  assign in_item.ready = (cnt_r == 2'd0) || (cnt_r == 2'd1 && pop);

  assign tv_take = glt_pkg::is_digit(c) || c == glt_pkg::CH_POINT ||
                   ((c == glt_pkg::CH_PLUS || c == glt_pkg::CH_MINUS) && !nonempty_r);

  assign ln_div = (32'(fcnt_r) > 32'(glt_pkg::DIV_CAP)) ? glt_pkg::DIV_CAP
                                                        : glt_pkg::DIV_W'(fcnt_r);

  always_comb begin
    lx_nxt       = lx_r;
    cm_nxt       = cm_r;
    letter_nxt   = letter_r;
    sign_nxt     = sign_r;
    acc_nxt      = acc_r;
    dcnt_nxt     = dcnt_r;
    fcnt_nxt     = fcnt_r;
    point_nxt    = point_r;
    ignore_nxt   = ignore_r;
    nonempty_nxt = nonempty_r;
    del_nxt      = del_r;
    pct_nxt      = pct_r;
    res_nxt[0]   = '0;
    res_nxt[1]   = '0;
    n_res        = 2'd0;
    div0_nxt     = '0;
    ws           = 1'b0;
    uk           = 1'b0;
    ucm          = cm_r;

    if (in_item.req_type) begin
      if (cm_r == glt_pkg::CM_UNK) begin
        res_nxt[n_res[0]] = glt_pkg::mk_err(glt_pkg::ERR_UNK_WORD);
        n_res = n_res + 2'd1;
      end else if (cm_r == glt_pkg::CM_UNKNUM) begin
        res_nxt[n_res[0]] = glt_pkg::mk_err(glt_pkg::ERR_UNK_NUM);
        n_res = n_res + 2'd1;
      end
      if (lx_r == glt_pkg::LX_LINENO) begin
        if (nonempty_r) begin
          res_nxt[n_res[0]] = glt_pkg::mk_tok(glt_pkg::TK_LINENO, 8'h00, sign_r, acc_r,
                                              '0, glt_pkg::ERR_MULTI_POINT, 1'b0, 1'b0);
          div0_nxt = ln_div;
        end else begin
          res_nxt[n_res[0]] = glt_pkg::mk_err(glt_pkg::ERR_EMPTY_LINENO);
        end
        n_res = n_res + 2'd1;
      end else if (lx_r == glt_pkg::LX_WNUM) begin
        if (nonempty_r) begin
          res_nxt[n_res[0]] = glt_pkg::mk_tok(glt_pkg::TK_WORD, letter_r, sign_r, acc_r,
                                              glt_pkg::FRAC_W'(fcnt_r),
                                              glt_pkg::ERR_MULTI_POINT, 1'b0, 1'b0);
        end else begin
          res_nxt[n_res[0]] = glt_pkg::mk_err(glt_pkg::ERR_UNK_WORD);
        end
        n_res = n_res + 2'd1;
      end
      res_nxt[n_res[0]] = glt_pkg::mk_tok(glt_pkg::TK_EOL, 8'h00, 1'b0, '0, '0,
                                          glt_pkg::ERR_MULTI_POINT, del_r, pct_r);
      n_res = n_res + 2'd1;
      lx_nxt       = glt_pkg::LX_START;
      cm_nxt       = glt_pkg::CM_NONE;
      letter_nxt   = 8'h00;
      sign_nxt     = 1'b0;
      acc_nxt      = '0;
      dcnt_nxt     = '0;
      fcnt_nxt     = '0;
      point_nxt    = 1'b0;
      ignore_nxt   = 1'b0;
      nonempty_nxt = 1'b0;
      del_nxt      = 1'b0;
      pct_nxt      = 1'b0;
    end else begin
      unique case (cm_r)
        glt_pkg::CM_INLINE: begin
          if (c == glt_pkg::CH_RPAREN) begin
            cm_nxt = glt_pkg::CM_NONE;
          end else begin
            res_nxt[n_res[0]] = glt_pkg::mk_tok(glt_pkg::TK_CMT_CHAR, c, 1'b0, '0, '0,
                                                glt_pkg::ERR_MULTI_POINT, 1'b0, 1'b0);
            n_res = n_res + 2'd1;
          end
        end
        glt_pkg::CM_EOL: begin
          res_nxt[n_res[0]] = glt_pkg::mk_tok(glt_pkg::TK_CMT_CHAR, c, 1'b0, '0, '0,
                                              glt_pkg::ERR_MULTI_POINT, 1'b0, 1'b0);
          n_res = n_res + 2'd1;
        end
        glt_pkg::CM_UNK, glt_pkg::CM_UNKNUM: begin
          uk = 1'b1;
        end
        glt_pkg::CM_NONE: begin
          if (!glt_pkg::is_space(c)) begin
            unique case (lx_r)
              glt_pkg::LX_START: begin
                if (c == glt_pkg::CH_SLASH) begin
                  del_nxt = 1'b1;
                end else if (c == glt_pkg::CH_PERCENT) begin
                  pct_nxt = 1'b1;
                  cm_nxt  = glt_pkg::CM_EOL;
                  lx_nxt  = glt_pkg::LX_WSTART;
                  res_nxt[n_res[0]] = glt_pkg::mk_tok(glt_pkg::TK_CMT_START, c, 1'b0, '0,
                                                      '0, glt_pkg::ERR_MULTI_POINT,
                                                      1'b0, 1'b0);
                  n_res = n_res + 2'd1;
                end else if (c == glt_pkg::CH_N_UP || c == glt_pkg::CH_N_LOW) begin
                  sign_nxt     = 1'b0;
                  acc_nxt      = '0;
                  dcnt_nxt     = '0;
                  fcnt_nxt     = '0;
                  point_nxt    = 1'b0;
                  ignore_nxt   = 1'b0;
                  nonempty_nxt = 1'b0;
                  lx_nxt       = glt_pkg::LX_LINENO;
                end else begin
                  lx_nxt = glt_pkg::LX_WSTART;
                  ws     = 1'b1;
                end
              end
              glt_pkg::LX_LINENO, glt_pkg::LX_WNUM: begin
                if (c != glt_pkg::CH_LPAREN && c != glt_pkg::CH_SEMI && tv_take) begin
                  if (glt_pkg::is_digit(c)) begin
                    if (!ignore_r) begin
                      if (32'(dcnt_r) >= MAX_DIGITS) begin
                        res_nxt[n_res[0]] = glt_pkg::mk_err(glt_pkg::ERR_DIGITS);
                        n_res = n_res + 2'd1;
                        ignore_nxt = 1'b1;
                      end else begin
                        acc_nxt = glt_pkg::MANT_W'(33'({acc_r, 3'b000}) +
                                                   33'({acc_r, 1'b0}) + 33'(c[3:0]));
                        dcnt_nxt = dcnt_r + DW'(1);
                        if (point_r) begin
                          fcnt_nxt = fcnt_r + DW'(1);
                        end
                        nonempty_nxt = 1'b1;
                      end
                    end
                  end else if (c == glt_pkg::CH_POINT) begin
                    if (point_r) begin
                      res_nxt[n_res[0]] = glt_pkg::mk_err(glt_pkg::ERR_MULTI_POINT);
                      n_res = n_res + 2'd1;
                      ignore_nxt = 1'b1;
                    end else begin
                      point_nxt    = 1'b1;
                      nonempty_nxt = 1'b1;
                    end
                  end else if (!ignore_r) begin
                    nonempty_nxt = 1'b1;
                    sign_nxt     = (c == glt_pkg::CH_MINUS);
                  end
                end else begin
                  lx_nxt = glt_pkg::LX_WSTART;
                  if (lx_r == glt_pkg::LX_LINENO) begin
                    if (nonempty_r) begin
                      res_nxt[n_res[0]] = glt_pkg::mk_tok(glt_pkg::TK_LINENO, 8'h00, sign_r,
                                                          acc_r, '0,
                                                          glt_pkg::ERR_MULTI_POINT,
                                                          1'b0, 1'b0);
                      div0_nxt = ln_div;
                    end else begin
                      res_nxt[n_res[0]] = glt_pkg::mk_err(glt_pkg::ERR_EMPTY_LINENO);
                    end
                    n_res = n_res + 2'd1;
                    ws = 1'b1;
                  end else if (nonempty_r) begin
                    res_nxt[n_res[0]] = glt_pkg::mk_tok(glt_pkg::TK_WORD, letter_r, sign_r,
                                                        acc_r, glt_pkg::FRAC_W'(fcnt_r),
                                                        glt_pkg::ERR_MULTI_POINT,
                                                        1'b0, 1'b0);
                    n_res = n_res + 2'd1;
                    ws = 1'b1;
                  end else if (c == glt_pkg::CH_LPAREN || c == glt_pkg::CH_SEMI) begin
                    res_nxt[n_res[0]] = glt_pkg::mk_err(glt_pkg::ERR_UNK_WORD);
                    n_res = n_res + 2'd1;
                    ws = 1'b1;
                  end else begin
                    cm_nxt = glt_pkg::CM_UNK;
                    ucm    = glt_pkg::CM_UNK;
                    uk     = 1'b1;
                  end
                end
              end
              glt_pkg::LX_WSTART: begin
                ws = 1'b1;
              end
            endcase
          end
        end
        default: begin
          cm_nxt = glt_pkg::CM_NONE;
        end
      endcase

      if (uk) begin
        if (ucm == glt_pkg::CM_UNK) begin
          if (glt_pkg::is_space(c)) begin
            res_nxt[n_res[0]] = glt_pkg::mk_err(glt_pkg::ERR_UNK_WORD);
            n_res = n_res + 2'd1;
            cm_nxt = glt_pkg::CM_NONE;
          end else if (glt_pkg::is_numish(c)) begin
            cm_nxt = glt_pkg::CM_UNKNUM;
          end
        end else if (!glt_pkg::is_numish(c)) begin
          res_nxt[n_res[0]] = glt_pkg::mk_err(glt_pkg::ERR_UNK_NUM);
          n_res = n_res + 2'd1;
          cm_nxt = glt_pkg::CM_NONE;
          ws = !glt_pkg::is_space(c);
        end
      end

      if (ws) begin
        if (c == glt_pkg::CH_LPAREN || c == glt_pkg::CH_SEMI) begin
          cm_nxt = (c == glt_pkg::CH_LPAREN) ? glt_pkg::CM_INLINE : glt_pkg::CM_EOL;
          res_nxt[n_res[0]] = glt_pkg::mk_tok(glt_pkg::TK_CMT_START, c, 1'b0, '0, '0,
                                              glt_pkg::ERR_MULTI_POINT, 1'b0, 1'b0);
          n_res = n_res + 2'd1;
        end else if (!(glt_pkg::is_letter(c) || c == glt_pkg::CH_HASH)) begin
          res_nxt[n_res[0]] = glt_pkg::mk_err(glt_pkg::ERR_BAD_START);
          n_res = n_res + 2'd1;
        end else begin
          letter_nxt   = c;
          sign_nxt     = 1'b0;
          acc_nxt      = '0;
          dcnt_nxt     = '0;
          fcnt_nxt     = '0;
          point_nxt    = 1'b0;
          ignore_nxt   = 1'b0;
          nonempty_nxt = 1'b0;
          lx_nxt       = glt_pkg::LX_WNUM;
        end
      end
    end

    if (n_res != 2'd0) begin
      res_nxt[1'(n_res - 2'd1)].last = 1'b1;
    end
  end

  // divide the head mantissa by ten
  assign prod   = 62'(slot_r[0].mant) * 62'(glt_pkg::RECIP_10);
  assign mant_q = glt_pkg::MANT_W'(prod[61:35]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lx_r       <= glt_pkg::LX_START;
      cm_r       <= glt_pkg::CM_NONE;
      letter_r   <= 8'h00;
      sign_r     <= 1'b0;
      acc_r      <= '0;
      dcnt_r     <= '0;
      fcnt_r     <= '0;
      point_r    <= 1'b0;
      ignore_r   <= 1'b0;
      nonempty_r <= 1'b0;
      del_r      <= 1'b0;
      pct_r      <= 1'b0;
      cnt_r      <= 2'd0;
      div_r      <= '0;
    end else begin
      if (accept) begin
        lx_r       <= lx_nxt;
        cm_r       <= cm_nxt;
        letter_r   <= letter_nxt;
        sign_r     <= sign_nxt;
        acc_r      <= acc_nxt;
        dcnt_r     <= dcnt_nxt;
        fcnt_r     <= fcnt_nxt;
        point_r    <= point_nxt;
        ignore_r   <= ignore_nxt;
        nonempty_r <= nonempty_nxt;
        del_r      <= del_nxt;
        pct_r      <= pct_nxt;
        cnt_r      <= n_res;
        div_r      <= div0_nxt;
      end else if (pop) begin
        cnt_r <= cnt_r - 2'd1;
      end else if (cnt_r != 2'd0 && div_r != '0) begin
        div_r <= div_r - glt_pkg::DIV_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot_r[0] <= res_nxt[0];
      slot_r[1] <= res_nxt[1];
    end else if (pop) begin
      slot_r[0] <= slot_r[1];
    end else if (cnt_r != 2'd0 && div_r != '0) begin
      slot_r[0].mant <= mant_q;
    end
  end

  assign out_tok.valid           = (cnt_r != 2'd0) && (div_r == '0);
  assign out_tok.token_kind      = slot_r[0].kind;
  assign out_tok.letter_or_char  = slot_r[0].letter;
  assign out_tok.value_negative  = slot_r[0].neg;
  assign out_tok.mantissa        = slot_r[0].mant;
  assign out_tok.fraction_digits = slot_r[0].frac;
  assign out_tok.error_code      = slot_r[0].err;
  assign out_tok.block_delete    = slot_r[0].bd;
  assign out_tok.percent_line    = slot_r[0].pct;
  assign out_tok.last_of_run     = slot_r[0].last;

  `ASSERT_ALWAYS(a_cnt_range, clk, rst_n, cnt_r != 2'd3, "token buffer count out of range")
  `ASSERT_ALWAYS(a_div_lineno, clk, rst_n, div_r == '0 || (cnt_r != 2'd0 && slot_r[0].kind == glt_pkg::TK_LINENO), "scaling a token that is no line number")
  `ASSERT_ALWAYS(a_last_mark, clk, rst_n, cnt_r != 2'd1 || slot_r[0].last, "single buffered token not marked last")
  `ASSERT_NEXT(a_eol_clear, clk, rst_n, accept && in_item.req_type, lx_r == glt_pkg::LX_START && cm_r == glt_pkg::CM_NONE && cnt_r != 2'd0, "end of line left lexer state behind")

endmodule

`default_nettype wire

// File: test/tb_gcode_line_tokenizer.sv
// Self-checking testbench of the G-code line tokenizer: directed and random lines, random stalls.
module tb_gcode_line_tokenizer;
  timeunit 1ns;
  timeprecision 1ps;

  import glt_pkg::*;

  localparam int DIGIT_LIMIT    = 9;
  localparam int ITEM_TARGET    = 380;
  localparam int HOLDOFF_CYCLES = 150;
  localparam int IDLE_LIMIT     = 2000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int REPORT_MAX     = 10;

  logic clk = 1'b0;
  logic rst_n;

  glt_in_if  in_ch ();
  glt_out_if out_ch ();

  gcode_line_tokenizer #(
    .MAX_DIGITS(DIGIT_LIMIT)
  ) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_item (in_ch),
    .out_tok (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Lexer state mirror
  lx_mode_t    lx_st;
  cm_mode_t    cm_st;
  logic [7:0]  word_ch;
  logic        val_neg;
  logic [29:0] val_acc;
  int unsigned val_digits;
  int unsigned val_frac;
  bit          val_point;
  bit          val_skip;
  bit          val_any;
  bit          line_del;
  bit          line_pct;

  tok_t step_toks[$];
  tok_t tokens_due[$];
  logic [7:0] line_buf[$];

  int  items_sent;
  int  mismatch_count;
  bit  source_idles;
  bit  sink_idles;
  int  holdoff_asked;
  int  holdoff_done;
  int  holdoff_left;
  int  stall_left;
  int  idle_cycles;

  function automatic bit is_blank(logic [7:0] c);
    return (c >= 8'h09 && c <= 8'h0D) || c == 8'h20 || c == 8'h85 || c == 8'hA0;
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) return 1'b1;
    if (c == 8'hAA || c == 8'hB5 || c == 8'hBA) return 1'b1;
    return c >= 8'hC0 && c != 8'hD7 && c != 8'hF7;
  endfunction

  function automatic bit is_dec(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic bit is_value_char(logic [7:0] c);
    return is_dec(c) || c == CH_PLUS || c == CH_MINUS || c == CH_POINT;
  endfunction

  task automatic put_tok(tok_kind_t k, logic [7:0] lc, logic ng, logic [29:0] m,
                         logic [3:0] f, err_code_t e, logic b, logic p);
    tok_t t;
    t.kind   = k;
    t.letter = lc;
    t.neg    = ng;
    t.mant   = m;
    t.frac   = f;
    t.err    = e;
    t.bd     = b;
    t.pct    = p;
    t.last   = 1'b0;
    step_toks.push_back(t);
  endtask

  task automatic put_err(err_code_t e);
    put_tok(TK_ERROR, 8'h00, 1'b0, '0, '0, e, 1'b0, 1'b0);
  endtask

  task automatic put_word();
    put_tok(TK_WORD, word_ch, val_neg, val_acc, 4'(val_frac), ERR_MULTI_POINT, 1'b0, 1'b0);
  endtask

  task automatic clear_value_regs();
    val_neg    = 1'b0;
    val_acc    = '0;
    val_digits = 0;
    val_frac   = 0;
    val_point  = 1'b0;
    val_skip   = 1'b0;
    val_any    = 1'b0;
  endtask

  task automatic clear_lexer();
    lx_st    = LX_START;
    cm_st    = CM_NONE;
    word_ch  = 8'h00;
    line_del = 1'b0;
    line_pct = 1'b0;
    clear_value_regs();
  endtask

  task automatic try_comment(input logic [7:0] c, output bit opened);
    opened = 1'b1;
    if (c == CH_LPAREN) begin
      cm_st = CM_INLINE;
      put_tok(TK_CMT_START, c, 1'b0, '0, '0, ERR_MULTI_POINT, 1'b0, 1'b0);
    end else if (c == CH_SEMI) begin
      cm_st = CM_EOL;
      put_tok(TK_CMT_START, c, 1'b0, '0, '0, ERR_MULTI_POINT, 1'b0, 1'b0);
    end else begin
      opened = 1'b0;
    end
  endtask

  task automatic take_value(input logic [7:0] c, output bit taken);
    taken = 1'b1;
    if (is_dec(c)) begin
      if (!val_skip) begin
        if (val_digits >= DIGIT_LIMIT) begin
          put_err(ERR_DIGITS);
          val_skip = 1'b1;
        end else begin
          val_acc = 30'(val_acc * 30'd10 + 30'(c - 8'h30));
          val_digits++;
          if (val_point) val_frac++;
          val_any = 1'b1;
        end
      end
    end else if (c == CH_POINT) begin
      if (val_point) begin
        put_err(ERR_MULTI_POINT);
        val_skip = 1'b1;
      end else begin
        val_point = 1'b1;
        val_any   = 1'b1;
      end
    end else if ((c == CH_PLUS || c == CH_MINUS) && !val_any) begin
      if (!val_skip) begin
        val_any = 1'b1;
        val_neg = (c == CH_MINUS);
      end
    end else begin
      taken = 1'b0;
    end
  endtask

  task automatic close_line_number();
    logic [29:0] v;
    if (val_any) begin
      v = val_acc;
      repeat (val_frac) v = v / 30'd10;
      put_tok(TK_LINENO, 8'h00, val_neg, v, '0, ERR_MULTI_POINT, 1'b0, 1'b0);
    end else begin
      put_err(ERR_EMPTY_LINENO);
    end
    lx_st = LX_WSTART;
  endtask

  task automatic begin_word(logic [7:0] c);
    bit opened;
    try_comment(c, opened);
    if (!opened) begin
      if (!(is_alpha(c) || c == CH_HASH)) begin
        put_err(ERR_BAD_START);
      end else begin
        word_ch = c;
        clear_value_regs();
        lx_st = LX_WNUM;
      end
    end
  endtask

  task automatic unknown_step(logic [7:0] c);
    if (cm_st == CM_UNK) begin
      if (is_blank(c)) begin
        put_err(ERR_UNK_WORD);
        cm_st = CM_NONE;
      end else if (is_value_char(c)) begin
        cm_st = CM_UNKNUM;
      end
    end else if (!is_value_char(c)) begin
      put_err(ERR_UNK_NUM);
      cm_st = CM_NONE;
      if (!is_blank(c)) begin_word(c);
    end
  endtask

  task automatic lexer_step(logic [7:0] c);
    bit taken;
    bit opened;
    case (lx_st)
      LX_START: begin
        if (c == CH_SLASH) begin
          line_del = 1'b1;
        end else if (c == CH_PERCENT) begin
          line_pct = 1'b1;
          cm_st    = CM_EOL;
          lx_st    = LX_WSTART;
          put_tok(TK_CMT_START, c, 1'b0, '0, '0, ERR_MULTI_POINT, 1'b0, 1'b0);
        end else begin
          lx_st = LX_WSTART;
          if (c == CH_N_UP || c == CH_N_LOW) begin
            clear_value_regs();
            lx_st = LX_LINENO;
          end else begin
            begin_word(c);
          end
        end
      end
      LX_LINENO: begin
        if (c == CH_LPAREN || c == CH_SEMI) begin
          close_line_number();
          try_comment(c, opened);
        end else begin
          take_value(c, taken);
          if (!taken) begin
            close_line_number();
            begin_word(c);
          end
        end
      end
      LX_WNUM: begin
        if (c == CH_LPAREN || c == CH_SEMI) begin
          lx_st = LX_WSTART;
          if (val_any) put_word();
          else put_err(ERR_UNK_WORD);
          try_comment(c, opened);
        end else begin
          take_value(c, taken);
          if (!taken) begin
            lx_st = LX_WSTART;
            if (val_any) begin
              put_word();
              begin_word(c);
            end else begin
              cm_st = CM_UNK;
              unknown_step(c);
            end
          end
        end
      end
      default: begin
        begin_word(c);
      end
    endcase
  endtask

  task automatic close_line();
    if (cm_st == CM_UNK) put_err(ERR_UNK_WORD);
    else if (cm_st == CM_UNKNUM) put_err(ERR_UNK_NUM);
    cm_st = CM_NONE;
    if (lx_st == LX_LINENO) begin
      close_line_number();
    end else if (lx_st == LX_WNUM) begin
      if (val_any) put_word();
      else put_err(ERR_UNK_WORD);
    end
    put_tok(TK_EOL, 8'h00, 1'b0, '0, '0, ERR_MULTI_POINT, line_del, line_pct);
    clear_lexer();
  endtask

  task automatic predict_tokens(bit eol, logic [7:0] c);
    step_toks.delete();
    if (eol) begin
      close_line();
    end else begin
      case (cm_st)
        CM_INLINE: begin
          if (c == CH_RPAREN) cm_st = CM_NONE;
          else put_tok(TK_CMT_CHAR, c, 1'b0, '0, '0, ERR_MULTI_POINT, 1'b0, 1'b0);
        end
        CM_EOL: begin
          put_tok(TK_CMT_CHAR, c, 1'b0, '0, '0, ERR_MULTI_POINT, 1'b0, 1'b0);
        end
        CM_UNK, CM_UNKNUM: begin
          unknown_step(c);
        end
        CM_NONE: begin
          if (!is_blank(c)) lexer_step(c);
        end
        default: begin
          cm_st = CM_NONE;
        end
      endcase
    end
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
    foreach (step_toks[i]) tokens_due.push_back(step_toks[i]);
  endtask

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_item(bit eol, logic [7:0] c);
    int gap;
    gap = 0;
    if (source_idles && $urandom_range(0, 99) < 45) gap = pick_idle();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.req_type  <= eol;
    in_ch.char_code <= c;
    do @(posedge clk); while (!in_ch.ready);
    predict_tokens(eol, c);
    items_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(1'b0, s[i]);
  endtask

  task automatic end_line();
    send_item(1'b1, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_line_buf();
    foreach (line_buf[i]) send_item(1'b0, line_buf[i]);
    end_line();
  endtask

  function automatic logic [7:0] pick_blank();
    int r;
    r = $urandom_range(0, 7);
    if (r < 5) return 8'(8'h09 + r);
    if (r == 5) return 8'h20;
    if (r == 6) return 8'h85;
    return 8'hA0;
  endfunction

  function automatic logic [7:0] pick_letter();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 8'(8'h41 + $urandom_range(0, 25));
    if (r < 85) return 8'(8'h61 + $urandom_range(0, 25));
    if (r < 92) return CH_HASH;
    return 8'($urandom_range(8'hC0, 8'hFF));
  endfunction

  task automatic add_value();
    int nd;
    int ppos;
    if ($urandom_range(0, 99) < 8) return;
    if ($urandom_range(0, 99) < 25) line_buf.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
    nd = ($urandom_range(0, 99) < 10) ? $urandom_range(8, 11) : $urandom_range(0, 4);
    ppos = ($urandom_range(0, 99) < 40) ? $urandom_range(0, nd) : -1;
    for (int i = 0; i < nd; i++) begin
      if (i == ppos) line_buf.push_back(CH_POINT);
      line_buf.push_back(8'(8'h30 + $urandom_range(0, 9)));
    end
    if (ppos == nd) line_buf.push_back(CH_POINT);
    if ($urandom_range(0, 99) < 5) begin
      line_buf.push_back(CH_POINT);
      line_buf.push_back(8'(8'h30 + $urandom_range(0, 9)));
    end
  endtask

  task automatic add_noise(int count);
    repeat (count) line_buf.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic build_random_line();
    int r;
    line_buf.delete();
    r = $urandom_range(0, 99);
    if (r < 10) begin
      add_noise($urandom_range(1, 8));
      return;
    end
    if (r < 25) begin
      repeat ($urandom_range(1, 2)) line_buf.push_back(CH_SLASH);
    end else if (r < 32) begin
      line_buf.push_back(CH_PERCENT);
      add_noise($urandom_range(0, 4));
      return;
    end
    if ($urandom_range(0, 99) < 45) begin
      line_buf.push_back($urandom_range(0, 3) ? CH_N_UP : CH_N_LOW);
      add_value();
    end
    repeat ($urandom_range(0, 4)) begin
      if ($urandom_range(0, 99) < 20) line_buf.push_back(pick_blank());
      line_buf.push_back(pick_letter());
      if ($urandom_range(0, 99) < 10) line_buf.push_back(pick_blank());
      add_value();
      if ($urandom_range(0, 99) < 10) add_noise(1);
      if ($urandom_range(0, 99) < 12) begin
        line_buf.push_back(CH_LPAREN);
        repeat ($urandom_range(0, 4)) line_buf.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 99) < 80) line_buf.push_back(CH_RPAREN);
      end
    end
    if ($urandom_range(0, 99) < 15) begin
      line_buf.push_back(CH_SEMI);
      add_noise($urandom_range(0, 3));
    end
  endtask

  task automatic test_directed_lines();
    send_text("/n-.5Y(");
    end_line();
    send_text("N;%");
    end_line();
    send_text("%");
    send_item(1'b0, 8'hFF);
    end_line();
    send_text("#999999999.98.");
    end_line();
    send_text("G@ H@1?");
    end_line();
    send_item(1'b0, 8'hA0);
    send_text("X1(a)B");
    end_line();
  endtask

  task automatic test_back_to_back_lines();
    int start;
    source_idles = 1'b0;
    sink_idles   = 1'b0;
    start = items_sent;
    while (items_sent - start < 40) begin
      build_random_line();
      send_line_buf();
    end
    source_idles = 1'b1;
    sink_idles   = 1'b1;
  endtask

  task automatic test_stalled_sink();
    int start;
    source_idles = 1'b0;
    holdoff_asked++;
    start = items_sent;
    while (items_sent - start < 25) begin
      build_random_line();
      send_line_buf();
    end
    source_idles = 1'b1;
  endtask

  task automatic test_random_lines();
    while (items_sent < ITEM_TARGET) begin
      build_random_line();
      send_line_buf();
    end
  endtask

  initial begin
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.req_type  <= 1'b0;
    in_ch.char_code <= 8'h00;
    items_sent     = 0;
    source_idles   = 1'b1;
    sink_idles     = 1'b1;
    holdoff_asked  = 0;
    clear_lexer();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_lines();
    test_back_to_back_lines();
    test_stalled_sink();
    test_random_lines();

    in_ch.valid <= 1'b0;
    while (tokens_due.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && tokens_due.size() == 0) begin
      $display("tb_gcode_line_tokenizer OK");
    end else begin
      $display("tb_gcode_line_tokenizer NOT OK");
    end
    $finish;
  end

  initial begin
    out_ch.ready <= 1'b0;
    holdoff_done = 0;
    holdoff_left = 0;
    stall_left   = 0;
    forever begin
      @(posedge clk);
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_ch.ready <= 1'b0;
      end else if (holdoff_done != holdoff_asked) begin
        holdoff_done++;
        holdoff_left = HOLDOFF_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (sink_idles && $urandom_range(0, 99) < 30) begin
        stall_left = pick_idle() - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  function automatic string tok_text(tok_t t);
    return $sformatf("kind=%0d chr=%02h neg=%0d mant=%0d frac=%0d err=%0d bd=%0d pct=%0d last=%0d",
                     t.kind, t.letter, t.neg, t.mant, t.frac, t.err, t.bd, t.pct, t.last);
  endfunction

  always @(posedge clk) begin
    tok_t got;
    tok_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.kind   = tok_kind_t'(out_ch.token_kind);
      got.letter = out_ch.letter_or_char;
      got.neg    = out_ch.value_negative;
      got.mant   = out_ch.mantissa;
      got.frac   = out_ch.fraction_digits;
      got.err    = err_code_t'(out_ch.error_code);
      got.bd     = out_ch.block_delete;
      got.pct    = out_ch.percent_line;
      got.last   = out_ch.last_of_run;
      if (tokens_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("%0t: token with none pending: %s", $realtime, tok_text(got));
      end else begin
        want = tokens_due.pop_front();
        if (got.kind !== want.kind || got.letter !== want.letter || got.neg !== want.neg ||
            got.mant !== want.mant || got.frac !== want.frac || got.err !== want.err ||
            got.bd !== want.bd || got.pct !== want.pct || got.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX) begin
            $display("%0t: token mismatch", $realtime);
            $display("  expected %s", tok_text(want));
            $display("  actual   %s", tok_text(got));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $realtime, IDLE_LIMIT);
      $display("tb_gcode_line_tokenizer NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial mismatch_count = 0;

endmodule
